@@ rtl/fat12_cluster_table_engine_macros.svh @@
// Assertion helpers; clk and rst_n must be in scope at the point of use.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define FAT12_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fat12 assertion failed");

// next-cycle implication
`define FAT12_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fat12 assertion failed");

`endif

@@ rtl/fat12_pkg.sv @@
package fat12_pkg;

    localparam int IDX_W = 13;
    localparam int CL_W  = 12;
    localparam int RV_W  = 12;

    localparam logic [CL_W-1:0] END_MARK = 12'hFFF;

    typedef enum logic [2:0] {
        REQ_LOAD   = 3'd0,
        REQ_READ   = 3'd1,
        REQ_LOOKUP = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_FREE   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CHAIN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_EVAL,
        S_WR_LAST,
        S_WR_NEXT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        logic    wr_load;
        logic    wr_b0;
        logic    wr_b1;
        logic    step_inc;
        logic    cnt_inc;
        logic    advance;
        logic    rv_we;
        logic    st_we;
        status_t st_code;
        logic    ld_out;
    } fat12_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       idx_ok;
        logic       cl_ok;
        logic       nxt_end;
        logic       nxt_bad;
        logic       limit_hit;
        logic       out_free;
    } fat12_sts_t;

endpackage

@@ rtl/fat12_req_if.sv @@
interface fat12_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] cluster;

    modport source (output valid, req_type, byte_index, byte_value, cluster, input ready);
    modport sink   (input valid, req_type, byte_index, byte_value, cluster, output ready);
endinterface

@@ rtl/fat12_rsp_if.sv @@
interface fat12_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] read_value;
    logic [1:0]  status;
    logic [11:0] freed_count;

    modport source (output valid, read_value, status, freed_count, input ready);
    modport sink   (input valid, read_value, status, freed_count, output ready);
endinterface

@@ rtl/fat12_ctrl.sv @@
`include "fat12_cluster_table_engine_macros.svh"

module fat12_ctrl
    import fat12_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fat12_sts_t sts,
    output fat12_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_FINISH;
                case (sts.req)
                    REQ_LOAD:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.wr_load = 1'b1;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end
                    end
                    REQ_READ:
                    begin
                        if (sts.idx_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end
                    end
                    REQ_LOOKUP, REQ_CLEAR, REQ_FREE:
                    begin
                        if (sts.cl_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_EVAL;
                        end
                        else
                        begin
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_EVAL:
            begin
                state_next = S_FINISH;
                case (sts.req)
                    REQ_READ, REQ_LOOKUP:
                    begin
                        cmd.rv_we = 1'b1;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.wr_b0  = 1'b1;
                        state_next = S_WR_LAST;
                    end
                    REQ_FREE:
                    begin
                        cmd.step_inc = 1'b1;
                        if (sts.nxt_end)
                        begin
                            cmd.wr_b0   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            state_next  = S_WR_LAST;
                        end
                        else if (sts.nxt_bad)
                        begin
                            // broken link: current entry stays as it is
                            cmd.st_we   = 1'b1;
                            cmd.st_code = ST_CHAIN;
                        end
                        else
                        begin
                            cmd.wr_b0   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            if (sts.limit_hit)
                            begin
                                cmd.st_we   = 1'b1;
                                cmd.st_code = ST_CHAIN;
                                state_next  = S_WR_LAST;
                            end
                            else
                            begin
                                state_next = S_WR_NEXT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_WR_LAST:
            begin
                cmd.wr_b1  = 1'b1;
                state_next = S_FINISH;
            end
            S_WR_NEXT:
            begin
                cmd.wr_b1   = 1'b1;
                cmd.advance = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FAT12_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISPATCH)
    `FAT12_ASSERT_NEXT(a_read_then_eval, state_reg == S_READ, state_reg == S_EVAL)

endmodule

@@ rtl/fat12_dp.sv @@
`include "fat12_cluster_table_engine_macros.svh"

module fat12_dp
    import fat12_pkg::*;
#(
    parameter int TABLE_BYTES = 4608
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fat12_cmd_t        cmd,
    output fat12_sts_t        sts,
    input  logic [2:0]        req_type,
    input  logic [IDX_W-1:0]  byte_index,
    input  logic [7:0]        byte_value,
    input  logic [CL_W-1:0]   cluster,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RV_W-1:0]   read_value,
    output logic [1:0]        status,
    output logic [11:0]       freed_count
);

    localparam int AW         = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int STEP_LIMIT = (TABLE_BYTES * 2) / 3;
    localparam int SW         = $clog2(STEP_LIMIT + 1);
    localparam int CW         = (SW > 12) ? SW : 12;

    localparam logic [IDX_W-1:0] BYTE_END  = IDX_W'(TABLE_BYTES);
    localparam logic [IDX_W-1:0] PAIR_END  = IDX_W'(TABLE_BYTES - 1);
    localparam logic [SW-1:0]    LIMIT_VAL = SW'(STEP_LIMIT);
    localparam logic [CW-1:0]    CNT_SAT   = CW'(12'hFFF);

    logic [7:0] mem [TABLE_BYTES];

    logic [2:0]       req_reg;
    logic [IDX_W-1:0] bidx_reg;
    logic [7:0]       bval_reg;
    logic [CL_W-1:0]  seed_reg;
    logic [SW-1:0]    steps_reg;
    logic [CW-1:0]    cnt_reg;
    status_t          status_reg;
    logic [RV_W-1:0]  rv_reg;
    logic [7:0]       rd0_reg;
    logic [7:0]       rd1_reg;
    logic             out_valid_reg;
    logic [RV_W-1:0]  out_rv_reg;
    logic [1:0]       out_st_reg;
    logic [11:0]      out_cnt_reg;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] nxt_idx;
    logic [CL_W-1:0]  entry;
    logic [7:0]       b0_clr;
    logic [7:0]       b1_clr;
    logic [AW-1:0]    rd_addr0;
    logic [AW-1:0]    rd_addr1;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;

    // byte index of an entry is c + c/2
    assign idx     = IDX_W'(seed_reg) + IDX_W'(seed_reg >> 1);
    assign idx1    = idx + 1'b1;
    assign entry   = seed_reg[0] ? {rd1_reg, rd0_reg[7:4]} : {rd1_reg[3:0], rd0_reg};
    assign nxt_idx = IDX_W'(entry) + IDX_W'(entry >> 1);
    assign b0_clr  = seed_reg[0] ? {4'h0, rd0_reg[3:0]} : 8'h00;
    assign b1_clr  = seed_reg[0] ? 8'h00 : {rd1_reg[7:4], 4'h0};

    assign sts.req       = req_reg;
    assign sts.idx_ok    = bidx_reg < BYTE_END;
    assign sts.cl_ok     = idx < PAIR_END;
    assign sts.nxt_end   = entry == END_MARK;
    assign sts.nxt_bad   = (entry == '0) || !(nxt_idx < PAIR_END);
    assign sts.limit_hit = SW'(steps_reg + 1'b1) == LIMIT_VAL;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign rd_addr0 = (req_reg == REQ_READ) ? bidx_reg[AW-1:0] : idx[AW-1:0];
    assign rd_addr1 = idx1[AW-1:0];

    always_comb
    begin
        mem_we = cmd.wr_load || cmd.wr_b0 || cmd.wr_b1;
        if (cmd.wr_load)
        begin
            wr_addr = bidx_reg[AW-1:0];
            wr_data = bval_reg;
        end
        else if (cmd.wr_b0)
        begin
            wr_addr = idx[AW-1:0];
            wr_data = b0_clr;
        end
        else
        begin
            wr_addr = idx1[AW-1:0];
            wr_data = b1_clr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= req_type;
            bidx_reg <= byte_index;
            bval_reg <= byte_value;
        end
        if (cmd.latch)
        begin
            seed_reg <= cluster;
        end
        else if (cmd.advance)
        begin
            seed_reg <= entry;
        end
        if (cmd.latch)
        begin
            rv_reg <= '0;
        end
        else if (cmd.rv_we)
        begin
            rv_reg <= (req_reg == REQ_READ) ? {4'h0, rd0_reg} : entry;
        end
        if (cmd.latch)
        begin
            status_reg <= ST_OK;
        end
        else if (cmd.st_we)
        begin
            status_reg <= cmd.st_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (cmd.latch)
        begin
            steps_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.step_inc)
            begin
                steps_reg <= SW'(steps_reg + 1'b1);
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
        end
    end

    // result slot: filled by the controller, emptied by the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_rv_reg  <= rv_reg;
            out_st_reg  <= status_reg;
            out_cnt_reg <= (cnt_reg > CNT_SAT) ? 12'hFFF : cnt_reg[11:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_rv_reg;
    assign status      = out_st_reg;
    assign freed_count = out_cnt_reg;

    `FAT12_ASSERT_NOW(a_no_overrun, cmd.ld_out, !out_valid_reg || out_ready)
    `FAT12_ASSERT_NOW(a_cnt_within_steps, 1'b1, cnt_reg <= CW'(steps_reg))
    `FAT12_ASSERT_NOW(a_step_bound, 1'b1, steps_reg <= LIMIT_VAL)

endmodule

@@ rtl/fat12_cluster_table_engine.sv @@
// FAT12 allocation table engine.
// req (sink): one request per beat - load byte, read byte, lookup next
// cluster, clear entry, free chain. rsp (source): exactly one result beat per
// request, in request order, carrying read_value, status and freed_count.
// The table is a TABLE_BYTES x 8 memory with one write port and two
// registered read ports; an entry's two bytes are read in the same cycle.
// After acceptance every request is dispatched and then finished. Load,
// range errors and unknown requests go straight on to finish; read and lookup
// add an evaluate step after the pair read; clear adds a low-byte write and a
// high-byte write; free chain gives each link a pair read, a low-byte write
// and a high-byte write on the single write port until the end mark, a broken
// link or the step limit stops the walk. One request is in flight at a time;
// req.ready is high only while the engine is idle.
// A finished result waits in the output register; the next request is taken
// while it waits, and is held at its finish until the slot empties, so a
// stalled receiver stops the engine after at most one further request.
// Reset empties the result slot and the controller; table contents are not
// cleared and must be loaded before they are read.
module fat12_cluster_table_engine
    import fat12_pkg::*;
#(
    parameter int TABLE_BYTES = 4608
)
(
    input  logic        clk,
    input  logic        rst_n,
    fat12_req_if.sink   req,
    fat12_rsp_if.source rsp
);

    fat12_cmd_t cmd;
    fat12_sts_t sts;

    fat12_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fat12_dp #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .byte_index  (req.byte_index),
        .byte_value  (req.byte_value),
        .cluster     (req.cluster),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .read_value  (rsp.read_value),
        .status      (rsp.status),
        .freed_count (rsp.freed_count)
    );

endmodule

@@ test/fat12_cluster_table_engine_tb.sv @@
module fat12_cluster_table_engine_tb
    import fat12_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_BYTES  = 4608;
    localparam int IDX_SPAN     = 1 << IDX_W;
    localparam int CL_SPAN      = 1 << CL_W;
    // clusters whose byte pair fits the table; also the walk step limit
    localparam int CLUSTERS     = (TABLE_BYTES * 2) / 3;
    localparam int TOP_CLUSTER  = CLUSTERS - 1;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 50;

    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic [CL_W-1:0]  cluster;
    } fat_req_t;

    typedef struct packed {
        logic [RV_W-1:0] read_value;
        status_t         status;
        logic [CL_W-1:0] freed_count;
    } fat_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    fat12_req_if req_ch ();
    fat12_rsp_if rsp_ch ();

    fat12_cluster_table_engine #(
        .TABLE_BYTES(TABLE_BYTES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always #10 clk = ~clk;

    // shadow of the allocation table
    logic [7:0] fat_mem [0:TABLE_BYTES-1];
    bit         loaded  [0:TABLE_BYTES-1];

    fat_rsp_t awaited_rsp [$];
    int       loaded_bytes [$];
    int       known_clusters [$];

    int err_count   = 0;
    int cycle_count = 0;
    int src_idle_pct;
    int snk_idle_pct;

    function automatic bit cluster_fits(input int c);
        return ((c * 3) / 2) + 1 < TABLE_BYTES;
    endfunction

    function automatic bit pair_loaded(input int c);
        int idx;
        idx = (c * 3) / 2;
        return loaded[idx] && loaded[idx + 1];
    endfunction

    function automatic logic [11:0] entry_of(input int c);
        int          idx;
        logic [15:0] pair;
        idx  = (c * 3) / 2;
        pair = {fat_mem[idx + 1], fat_mem[idx]};
        return (c % 2 != 0) ? pair[15:4] : pair[11:0];
    endfunction

    function automatic void wipe_entry(input int c);
        int idx;
        idx = (c * 3) / 2;
        if (c % 2 != 0) begin
            fat_mem[idx]     = fat_mem[idx] & 8'h0F;
            fat_mem[idx + 1] = 8'h00;
        end
        else begin
            fat_mem[idx]     = 8'h00;
            fat_mem[idx + 1] = fat_mem[idx + 1] & 8'hF0;
        end
    endfunction

    // applies one request to the shadow table and returns the result it gives
    function automatic fat_rsp_t apply_request(input fat_req_t r);
        fat_rsp_t    res;
        int          idx;
        int          seed;
        int          steps;
        int          cnt;
        bit          walking;
        logic [11:0] nxt;
        res  = '0;
        idx  = r.byte_index;
        seed = r.cluster;
        cnt  = 0;
        case (r.kind)
            REQ_LOAD:
                if (idx < TABLE_BYTES) begin
                    fat_mem[idx] = r.byte_value;
                    loaded[idx]  = 1'b1;
                    loaded_bytes.push_back(idx);
                    if (loaded_bytes.size() > 512)
                        void'(loaded_bytes.pop_front());
                end
                else
                    res.status = ST_RANGE;
            REQ_READ:
                if (idx < TABLE_BYTES)
                    res.read_value = {4'h0, fat_mem[idx]};
                else
                    res.status = ST_RANGE;
            REQ_LOOKUP:
                if (cluster_fits(seed))
                    res.read_value = entry_of(seed);
                else
                    res.status = ST_RANGE;
            REQ_CLEAR:
                if (cluster_fits(seed))
                    wipe_entry(seed);
                else
                    res.status = ST_RANGE;
            REQ_FREE:
                if (!cluster_fits(seed))
                    res.status = ST_RANGE;
                else begin
                    // successor is read before the current entry is cleared
                    res.status = ST_CHAIN;
                    steps      = 0;
                    walking    = 1'b1;
                    while (walking && steps < CLUSTERS) begin
                        nxt = entry_of(seed);
                        steps++;
                        if (nxt == END_MARK) begin
                            wipe_entry(seed);
                            cnt++;
                            res.status = ST_OK;
                            walking    = 1'b0;
                        end
                        else if (nxt == '0 || !cluster_fits(nxt))
                            walking = 1'b0;
                        else begin
                            wipe_entry(seed);
                            cnt++;
                            seed = nxt;
                        end
                    end
                    res.freed_count = (cnt > CL_SPAN - 1) ? {CL_W{1'b1}} : cnt[CL_W-1:0];
                end
            default: ;
        endcase
        return res;
    endfunction

    // a walk that only follows loaded pairs; revisits end on a cleared entry
    function automatic bit walk_reads_loaded(input int c);
        int          seed;
        logic [11:0] nxt;
        seed = c;
        for (int hops = 0; hops < 64; hops++) begin
            if (!pair_loaded(seed))
                return 1'b0;
            nxt = entry_of(seed);
            if (nxt == END_MARK || nxt == '0 || !cluster_fits(nxt))
                return 1'b1;
            seed = nxt;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_req(input logic [2:0] kind, input int idx, input int val, input int cl);
        fat_req_t r;
        r.kind       = kind;
        r.byte_index = idx[IDX_W-1:0];
        r.byte_value = val[7:0];
        r.cluster    = cl[CL_W-1:0];
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.kind;
        req_ch.byte_index <= r.byte_index;
        req_ch.byte_value <= r.byte_value;
        req_ch.cluster    <= r.cluster;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        awaited_rsp.push_back(apply_request(r));
    endtask

    task automatic do_load(input int idx, input int val);
        send_req(REQ_LOAD, idx, val, $urandom_range(CL_SPAN - 1));
    endtask

    task automatic do_read(input int idx);
        send_req(REQ_READ, idx, $urandom_range(255), $urandom_range(CL_SPAN - 1));
    endtask

    task automatic do_cluster(input req_t kind, input int cl);
        send_req(kind, $urandom_range(IDX_SPAN - 1), $urandom_range(255), cl);
    endtask

    // writes one 12-bit entry through two byte loads, keeping the neighbour's nibble
    task automatic set_entry(input int c, input int link);
        int          idx;
        logic [11:0] e;
        logic [3:0]  keep;
        idx  = (c * 3) / 2;
        e    = link[11:0];
        keep = 4'($urandom_range(15));
        if (c % 2 != 0) begin
            if (loaded[idx])
                keep = fat_mem[idx][3:0];
            do_load(idx, {e[3:0], keep});
            do_load(idx + 1, e[11:4]);
        end
        else begin
            if (loaded[idx + 1])
                keep = fat_mem[idx + 1][7:4];
            do_load(idx, e[7:0]);
            do_load(idx + 1, {keep, e[11:8]});
        end
        known_clusters.push_back(c);
        if (known_clusters.size() > 256)
            void'(known_clusters.pop_front());
    endtask

    function automatic int pick_cluster(input int region);
        case (region)
            0, 1:    return $urandom_range(255);
            2:       return $urandom_range(TOP_CLUSTER, TOP_CLUSTER - 255);
            default: return $urandom_range(TOP_CLUSTER);
        endcase
    endfunction

    function automatic int any_known_cluster();
        return known_clusters[$urandom_range(known_clusters.size() - 1)];
    endfunction

    task automatic test_lookup_basics();
        do_load(0, 'h23);
        do_load(1, 'h61);
        do_load(2, 'h45);
        do_cluster(REQ_LOOKUP, 0);
        do_cluster(REQ_LOOKUP, 1);
        do_read(1);
        do_load(TABLE_BYTES - 2, 'hA5);
        do_load(TABLE_BYTES - 1, 'hFF);
        do_cluster(REQ_LOOKUP, TOP_CLUSTER);
        do_read(TABLE_BYTES - 1);
    endtask

    task automatic test_range_errors();
        do_load(TABLE_BYTES, 'h00);
        do_load(IDX_SPAN - 1, 'hFF);
        do_read(TABLE_BYTES);
        do_read(IDX_SPAN - 1);
        do_cluster(REQ_LOOKUP, CLUSTERS);
        do_cluster(REQ_LOOKUP, CL_SPAN - 1);
        do_cluster(REQ_CLEAR, CLUSTERS);
        do_cluster(REQ_FREE, CL_SPAN - 1);
        send_req(REQ_UNKNOWN_LO, 0, 0, 0);
        send_req(REQ_UNKNOWN_HI, IDX_SPAN - 1, 'hFF, CL_SPAN - 1);
    endtask

    task automatic test_chain_cases();
        do_cluster(REQ_CLEAR, 1);
        do_cluster(REQ_LOOKUP, 0);
        do_cluster(REQ_LOOKUP, 1);
        // 2 -> 3 -> end mark
        do_load(3, 'h03);
        do_load(4, 'hF0);
        do_load(5, 'hFF);
        do_cluster(REQ_FREE, 2);
        do_cluster(REQ_LOOKUP, 2);
        // zero link, then a link past the table
        do_cluster(REQ_FREE, 1);
        do_cluster(REQ_FREE, TOP_CLUSTER);
        // cluster 4 points at itself
        do_load(6, 'h04);
        do_load(7, 'h00);
        do_cluster(REQ_FREE, 4);
    endtask

    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          pick;
        int          len;
        int          region;
        int          c;
        int          link;
        int          tail;
        bit          fresh;
        int          chain [$];
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                chain.delete();
                len    = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
                region = $urandom_range(3);
                while (chain.size() < len) begin
                    c     = pick_cluster(region);
                    fresh = 1'b1;
                    foreach (chain[i])
                        if (chain[i] == c)
                            fresh = 1'b0;
                    if (fresh)
                        chain.push_back(c);
                end
                for (int i = 0; i + 1 < len; i++)
                    set_entry(chain[i], chain[i + 1]);
                tail = $urandom_range(99);
                if (tail < 80)
                    link = END_MARK;
                else if (tail < 87)
                    link = 0;
                else if (tail < 94)
                    link = $urandom_range(CL_SPAN - 1, CLUSTERS);
                else
                    link = chain[$urandom_range(len - 1)];
                set_entry(chain[len - 1], link);
                sent += 2 * len;
                if ($urandom_range(2) == 0) begin
                    do_cluster(REQ_LOOKUP, chain[$urandom_range(len - 1)]);
                    sent++;
                end
                if ($urandom_range(4) == 0)
                    do_cluster(REQ_FREE, chain[$urandom_range(len - 1)]);
                else
                    do_cluster(REQ_FREE, chain[0]);
                sent++;
            end
            else if (pick < 70) begin
                if (known_clusters.size() == 0 || $urandom_range(9) == 0)
                    do_cluster(REQ_LOOKUP, $urandom_range(CL_SPAN - 1, CLUSTERS));
                else
                    do_cluster(REQ_LOOKUP, any_known_cluster());
                sent++;
            end
            else if (pick < 80) begin
                if (loaded_bytes.size() == 0 || $urandom_range(9) == 0)
                    do_read($urandom_range(IDX_SPAN - 1, TABLE_BYTES));
                else
                    do_read(loaded_bytes[$urandom_range(loaded_bytes.size() - 1)]);
                sent++;
            end
            else if (pick < 88) begin
                if (known_clusters.size() == 0 || $urandom_range(9) == 0)
                    do_cluster(REQ_CLEAR, $urandom_range(CL_SPAN - 1, CLUSTERS));
                else
                    do_cluster(REQ_CLEAR, any_known_cluster());
                sent++;
            end
            else if (pick < 96) begin
                do_load($urandom_range(IDX_SPAN - 1), $urandom_range(255));
                sent++;
            end
            else if (pick < 98) begin
                // free from wherever the table happens to lead, if that is all loaded
                if (known_clusters.size() != 0) begin
                    c = any_known_cluster();
                    if (walk_reads_loaded(c))
                        do_cluster(REQ_FREE, c);
                    else
                        do_cluster(REQ_LOOKUP, c);
                    sent++;
                end
            end
            else
                send_req(3'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO)),
                         $urandom_range(IDX_SPAN - 1), $urandom_range(255),
                         $urandom_range(CL_SPAN - 1));
        end
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk) begin : rsp_check
        fat_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_rsp.size() == 0)
                report_mismatch("result beat with nothing outstanding");
            else begin
                want = awaited_rsp.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              rsp_ch.read_value, want.read_value));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.freed_count !== want.freed_count)
                    report_mismatch($sformatf("freed_count %0d, want %0d",
                                              rsp_ch.freed_count, want.freed_count));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.byte_index = '0;
        req_ch.byte_value = '0;
        req_ch.cluster    = '0;
        src_idle_pct      = 30;
        snk_idle_pct      = 87;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_lookup_basics();
        test_range_errors();
        test_chain_cases();
        test_random_traffic(650);
        src_idle_pct = 87;
        snk_idle_pct = 30;
        test_random_traffic(650);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_traffic(650);

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && awaited_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fat12_pkg.sv
rtl/fat12_req_if.sv
rtl/fat12_rsp_if.sv
rtl/fat12_ctrl.sv
rtl/fat12_dp.sv
rtl/fat12_cluster_table_engine.sv
test/fat12_cluster_table_engine_tb.sv
